>>> src/sme_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stack machine executor package
// Shared constants, opcodes, status codes and types for the stack machine
// executor and its submodules.
// ----------------------------------------------------------------------------
package sme_pkg;

    // Stack geometry.
    localparam int STACK_DEPTH = 1024;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int SP_W        = 11;
    localparam int WORD_W      = 32;

    // Opcodes.
    localparam logic [7:0] OP_HALT = 8'd0;
    localparam logic [7:0] OP_PUSH = 8'd1;
    localparam logic [7:0] OP_ADD  = 8'd2;
    localparam logic [7:0] OP_SUB  = 8'd3;
    localparam logic [7:0] OP_MUL  = 8'd4;
    localparam logic [7:0] OP_DIV  = 8'd5;
    localparam logic [7:0] OP_MOD  = 8'd6;
    localparam logic [7:0] OP_RDI  = 8'd7;
    localparam logic [7:0] OP_WRI  = 8'd8;
    localparam logic [7:0] OP_RDC  = 8'd9;
    localparam logic [7:0] OP_WRC  = 8'd10;

    // Status codes.
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_HALTED    = 3'd1;
    localparam logic [2:0] ST_OVERFLOW  = 3'd2;
    localparam logic [2:0] ST_UNDERFLOW = 3'd3;
    localparam logic [2:0] ST_DIVZERO   = 3'd4;

    // Push constant handling.
    localparam logic [23:0]       IMM_MASK  = 24'hFF_FFFF;
    localparam logic [WORD_W-1:0] IMM_SIGN  = 32'h0080_0000;
    localparam logic [WORD_W-1:0] IMM_UPPER = 32'hFF00_0000;
    localparam logic [WORD_W-1:0] CHAR_MASK = 32'h0000_00FF;

    // Write port of the stack memory.
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [WORD_W-1:0] data;
    } sme_ram_wr_t;

    // Sign-extend the 24-bit push constant to a full word.
    function automatic logic [WORD_W-1:0] sext_imm(input logic [23:0] imm);
        logic [WORD_W-1:0] v;
        v = {8'd0, imm & IMM_MASK};
        if ((v & IMM_SIGN) != '0)
        begin
            v = v | IMM_UPPER;
        end
        return v;
    endfunction

endpackage

>>> src/sme_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Instruction request channel
// Valid/ready channel carrying one instruction and its read value.
// ----------------------------------------------------------------------------
interface sme_req_if;
    logic        valid;
    logic        ready;
    logic [7:0]  operation;
    logic [23:0] immediate;
    logic [31:0] read_value;

    modport source (output valid, operation, immediate, read_value, input ready);
    modport sink   (input valid, operation, immediate, read_value, output ready);
endinterface

>>> src/sme_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying the result of one instruction.
// ----------------------------------------------------------------------------
interface sme_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic        out_valid;
    logic [31:0] out_value;
    logic        out_is_char;
    logic [10:0] depth;

    modport source (output valid, status, out_valid, out_value, out_is_char, depth,
                    input ready);
    modport sink   (input valid, status, out_valid, out_value, out_is_char, depth,
                    output ready);
endinterface

>>> src/sme_stack_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stack memory
// Single write port, single read port word memory with registered read data.
// ----------------------------------------------------------------------------
module sme_stack_ram (
    input  logic                          clk,
    input  sme_pkg::sme_ram_wr_t          wr,
    input  logic [sme_pkg::ADDR_W-1:0]    rd_addr,
    output logic [sme_pkg::WORD_W-1:0]    rd_data
);
    import sme_pkg::*;

    logic [WORD_W-1:0] mem [STACK_DEPTH];
    logic [WORD_W-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> src/sme_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Signed iterative divider
// Restoring divider on magnitudes, one quotient bit per cycle, with the
// signs of quotient and remainder fixed up for truncation toward zero.
// ----------------------------------------------------------------------------
module sme_divider (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [sme_pkg::WORD_W-1:0] dividend,
    input  logic [sme_pkg::WORD_W-1:0] divisor,
    output logic                       done,
    output logic [sme_pkg::WORD_W-1:0] quotient,
    output logic [sme_pkg::WORD_W-1:0] remainder
);
    import sme_pkg::*;

    localparam int CNT_W = $clog2(WORD_W);

    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [WORD_W-1:0] q_reg;
    logic [WORD_W-1:0] rem_reg;
    logic [WORD_W-1:0] mb_reg;
    logic              neg_q_reg;
    logic              neg_r_reg;

    logic [WORD_W:0]   shifted;
    logic [WORD_W:0]   trial;

    // One restoring step: shift in the next dividend bit and try a subtract.
    always_comb
    begin
        shifted = {rem_reg, q_reg[WORD_W-1]};
        trial   = shifted - {1'b0, mb_reg};
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(WORD_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg     <= dividend[WORD_W-1] ? (WORD_W'(0) - dividend) : dividend;
            mb_reg    <= divisor[WORD_W-1] ? (WORD_W'(0) - divisor) : divisor;
            rem_reg   <= '0;
            neg_q_reg <= dividend[WORD_W-1] ^ divisor[WORD_W-1];
            neg_r_reg <= dividend[WORD_W-1];
        end
        else if (busy_reg)
        begin
            if (!trial[WORD_W])
            begin
                rem_reg <= trial[WORD_W-1:0];
                q_reg   <= {q_reg[WORD_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted[WORD_W-1:0];
                q_reg   <= {q_reg[WORD_W-2:0], 1'b0};
            end
        end
    end

    // Sign correction of the results.
    assign quotient  = neg_q_reg ? (WORD_W'(0) - q_reg) : q_reg;
    assign remainder = neg_r_reg ? (WORD_W'(0) - rem_reg) : rem_reg;
    assign done      = done_reg;

endmodule

>>> src/stack_machine_executor_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stack machine executor
// Executes one instruction per request on a 1024-entry, 32-bit operand stack
// and returns one result per instruction.
// ----------------------------------------------------------------------------
// One instruction is in flight at a time. Push, read, halt, unknown opcodes,
// stack overflow and stack underflow go from decode straight to done; write
// integer and write char pass through a read state; add, sub and mul fetch
// both operands in turn through the single read port of the stack memory,
// then execute and write back; div and mod run the 32 iterations of the
// shared restoring divider before write back, and div and mod by zero skip
// it. A finished result waits in an output register, so the next request is
// accepted as soon as the sequencer is back in idle. The stack memory has no
// reset and needs no clearing pass.
module stack_machine_executor_unit (
    input  logic       clk,
    input  logic       rst_n,
    sme_req_if.sink    req,
    sme_rsp_if.source  rsp
);
    import sme_pkg::*;

    // Sequencer states.
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_RD_A   = 3'd2;
    localparam logic [2:0] S_EXEC   = 3'd3;
    localparam logic [2:0] S_DIV    = 3'd4;
    localparam logic [2:0] S_WB     = 3'd5;
    localparam logic [2:0] S_WRD    = 3'd6;
    localparam logic [2:0] S_DONE   = 3'd7;

    logic [2:0]        state_reg,      state_next;
    logic [SP_W-1:0]   sp_reg,         sp_next;
    logic              halted_reg,     halted_next;
    logic [7:0]        op_reg,         op_next;
    logic [23:0]       imm_reg,        imm_next;
    logic [WORD_W-1:0] rdv_reg,        rdv_next;
    logic [WORD_W-1:0] b_reg,          b_next;
    logic [WORD_W-1:0] res_reg,        res_next;
    logic [2:0]        status_reg,     status_next;
    logic              oval_reg,       oval_next;
    logic [WORD_W-1:0] ovalue_reg,     ovalue_next;
    logic              ochar_reg,      ochar_next;

    logic              rsp_valid_reg,  rsp_valid_next;
    logic [2:0]        rsp_status_reg, rsp_status_next;
    logic              rsp_oval_reg,   rsp_oval_next;
    logic [WORD_W-1:0] rsp_value_reg,  rsp_value_next;
    logic              rsp_char_reg,   rsp_char_next;
    logic [SP_W-1:0]   rsp_depth_reg,  rsp_depth_next;

    sme_ram_wr_t       ram_wr;
    logic [ADDR_W-1:0] rd_addr;
    logic [WORD_W-1:0] rd_data;

    logic              div_start;
    logic              div_done;
    logic [WORD_W-1:0] div_q;
    logic [WORD_W-1:0] div_r;

    logic [SP_W-1:0]   sp_m1;
    logic [SP_W-1:0]   sp_m2;
    logic [2*WORD_W-1:0] product;

    assign sp_m1   = sp_reg - SP_W'(1);
    assign sp_m2   = sp_reg - SP_W'(2);
    assign product = rd_data * b_reg;

    sme_stack_ram u_ram (
        .clk     (clk),
        .wr      (ram_wr),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    sme_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (rd_data),
        .divisor   (b_reg),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    // Sequencer and next-state logic.
    always_comb
    begin
        state_next      = state_reg;
        sp_next         = sp_reg;
        halted_next     = halted_reg;
        op_next         = op_reg;
        imm_next        = imm_reg;
        rdv_next        = rdv_reg;
        b_next          = b_reg;
        res_next        = res_reg;
        status_next     = status_reg;
        oval_next       = oval_reg;
        ovalue_next     = ovalue_reg;
        ochar_next      = ochar_reg;
        rsp_valid_next  = rsp_valid_reg & ~rsp.ready;
        rsp_status_next = rsp_status_reg;
        rsp_oval_next   = rsp_oval_reg;
        rsp_value_next  = rsp_value_reg;
        rsp_char_next   = rsp_char_reg;
        rsp_depth_next  = rsp_depth_reg;
        ram_wr          = '0;
        rd_addr         = sp_m1[ADDR_W-1:0];
        div_start       = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    op_next     = req.operation;
                    imm_next    = req.immediate;
                    rdv_next    = req.read_value;
                    status_next = ST_OK;
                    oval_next   = 1'b0;
                    ovalue_next = '0;
                    ochar_next  = 1'b0;
                    state_next  = S_DECODE;
                end
            end

            S_DECODE:
            begin
                state_next = S_DONE;
                if (halted_reg)
                begin
                    status_next = ST_HALTED;
                end
                else
                begin
                    case (op_reg) inside
                        OP_HALT:
                        begin
                            halted_next = 1'b1;
                            status_next = ST_HALTED;
                        end
                        OP_PUSH, OP_RDI, OP_RDC:
                        begin
                            if (sp_reg >= SP_W'(STACK_DEPTH))
                            begin
                                status_next = ST_OVERFLOW;
                            end
                            else
                            begin
                                ram_wr.en   = 1'b1;
                                ram_wr.addr = sp_reg[ADDR_W-1:0];
                                if (op_reg == OP_PUSH)
                                begin
                                    ram_wr.data = sext_imm(imm_reg);
                                end
                                else if (op_reg == OP_RDI)
                                begin
                                    ram_wr.data = rdv_reg;
                                end
                                else
                                begin
                                    ram_wr.data = rdv_reg & CHAR_MASK;
                                end
                                sp_next = sp_reg + SP_W'(1);
                            end
                        end
                        [OP_ADD:OP_MOD]:
                        begin
                            if (sp_reg < SP_W'(2))
                            begin
                                status_next = ST_UNDERFLOW;
                            end
                            else
                            begin
                                // Fetch the top entry first.
                                rd_addr    = sp_m1[ADDR_W-1:0];
                                state_next = S_RD_A;
                            end
                        end
                        OP_WRI, OP_WRC:
                        begin
                            if (sp_reg == '0)
                            begin
                                status_next = ST_UNDERFLOW;
                            end
                            else
                            begin
                                rd_addr    = sp_m1[ADDR_W-1:0];
                                state_next = S_WRD;
                            end
                        end
                        default:
                        begin
                            status_next = ST_OK;
                        end
                    endcase
                end
            end

            S_RD_A:
            begin
                // Top entry arrives; fetch the one below it.
                b_next     = rd_data;
                rd_addr    = sp_m2[ADDR_W-1:0];
                state_next = S_EXEC;
            end

            S_EXEC:
            begin
                state_next = S_WB;
                case (op_reg)
                    OP_ADD:
                    begin
                        res_next = rd_data + b_reg;
                    end
                    OP_SUB:
                    begin
                        res_next = rd_data - b_reg;
                    end
                    OP_MUL:
                    begin
                        res_next = product[WORD_W-1:0];
                    end
                    default:
                    begin
                        if (b_reg == '0)
                        begin
                            status_next = ST_DIVZERO;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            div_start  = 1'b1;
                            state_next = S_DIV;
                        end
                    end
                endcase
            end

            S_DIV:
            begin
                if (div_done)
                begin
                    res_next   = (op_reg == OP_DIV) ? div_q : div_r;
                    state_next = S_WB;
                end
            end

            S_WB:
            begin
                ram_wr.en   = 1'b1;
                ram_wr.addr = sp_m2[ADDR_W-1:0];
                ram_wr.data = res_reg;
                sp_next     = sp_m1;
                state_next  = S_DONE;
            end

            S_WRD:
            begin
                oval_next = 1'b1;
                sp_next   = sp_m1;
                if (op_reg == OP_WRC)
                begin
                    ovalue_next = rd_data & CHAR_MASK;
                    ochar_next  = 1'b1;
                end
                else
                begin
                    ovalue_next = rd_data;
                    ochar_next  = 1'b0;
                end
                state_next = S_DONE;
            end

            S_DONE:
            begin
                // Hand the result to the output register once it is free.
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_status_next = status_reg;
                    rsp_oval_next   = oval_reg;
                    rsp_value_next  = ovalue_reg;
                    rsp_char_next   = ochar_reg;
                    rsp_depth_next  = sp_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            sp_reg        <= '0;
            halted_reg    <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sp_reg        <= sp_next;
            halted_reg    <= halted_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        imm_reg        <= imm_next;
        rdv_reg        <= rdv_next;
        b_reg          <= b_next;
        res_reg        <= res_next;
        status_reg     <= status_next;
        oval_reg       <= oval_next;
        ovalue_reg     <= ovalue_next;
        ochar_reg      <= ochar_next;
        rsp_status_reg <= rsp_status_next;
        rsp_oval_reg   <= rsp_oval_next;
        rsp_value_reg  <= rsp_value_next;
        rsp_char_reg   <= rsp_char_next;
        rsp_depth_reg  <= rsp_depth_next;
    end

    // Channel outputs.
    assign req.ready       = (state_reg == S_IDLE);
    assign rsp.valid       = rsp_valid_reg;
    assign rsp.status      = rsp_status_reg;
    assign rsp.out_valid   = rsp_oval_reg;
    assign rsp.out_value   = rsp_value_reg;
    assign rsp.out_is_char = rsp_char_reg;
    assign rsp.depth       = rsp_depth_reg;

endmodule

>>> src/sme_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stack machine executor checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module sme_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic [2:0]  status,
    input logic        out_valid,
    input logic [31:0] out_value,
    input logic        out_is_char,
    input logic [10:0] depth
);
    import sme_pkg::*;

    // A stalled result holds its payload.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(out_valid)
            && $stable(out_value) && $stable(out_is_char) && $stable(depth))
        else $error("result changed while stalled");

    // Without an emitted value the value fields are zero.
    a_no_emit_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !out_valid |-> out_value == '0 && !out_is_char)
        else $error("value fields set without an emitted value");

    // An emitted value only comes with an ok status; characters are 8 bits.
    a_emit_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && out_valid |-> status == ST_OK
            && (!out_is_char || out_value[31:8] == '0))
        else $error("bad emitted value");

    // The reported depth never exceeds the stack size and the status is a known code.
    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> depth <= 11'(STACK_DEPTH) && status <= ST_DIVZERO)
        else $error("depth or status out of range");

endmodule

bind stack_machine_executor_unit sme_checker u_sme_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .status      (rsp.status),
    .out_valid   (rsp.out_valid),
    .out_value   (rsp.out_value),
    .out_is_char (rsp.out_is_char),
    .depth       (rsp.depth)
);
